// ===== hdl/tpd_pkg.sv =====
// shared types and constants of the transient peak detector
package tpd_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int ALPHA_W    = 16;
	localparam int WIN_W      = 7;
	localparam int ENERGY_W   = 40;
	localparam int REFR_W     = 13;
	localparam int IDX_W      = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 40;
	localparam int MIN_WINDOW = 3;

	localparam logic [ALPHA_W-1:0]  HP_ALPHA_RST  = 16'd64772;
	localparam logic [WIN_W-1:0]    WINDOW_RST    = 7'd43;
	localparam logic [ENERGY_W-1:0] THRESHOLD_RST = 40'd1048576;
	localparam logic [REFR_W-1:0]   REFR_RST      = 13'd1344;

	localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};

	// result queue
	localparam int OQ_DEPTH = 4;
	localparam int OQ_PTR_W = 2;
	localparam int OQ_CNT_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HP_ALPHA   = 2'd0,
		REG_WINDOW_LEN = 2'd1,
		REG_THRESHOLD  = 2'd2,
		REG_REFRACTORY = 2'd3
	} cfg_reg_t;

	// control that travels with a sample down the pipeline
	typedef struct packed {
		logic             vld;
		logic             last;
		logic [IDX_W-1:0] idx;
	} stage_t;

	typedef struct packed {
		logic [ENERGY_W-1:0] energy;
		logic [IDX_W-1:0]    idx;
	} out_item_t;

endpackage

// ===== hdl/tpd_filter.sv =====
// high-pass filter with rounding, saturation and squaring
module tpd_filter import tpd_pkg::*; #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic [SAMPLE_W-1:0]         sample,
	input  logic [ALPHA_W-1:0]          hp_alpha,
	input  stage_t                      st_s1,
	input  stage_t                      st_s2,
	output logic [2*(SAMPLE_BITS+1)-1:0] sq_s3
);

	localparam int F_W  = SAMPLE_BITS + 2;
	localparam int D_W  = SAMPLE_BITS + 3;
	localparam int P_W  = D_W + ALPHA_W + 1;
	localparam int R_W  = P_W - 16;
	localparam int SQ_W = 2 * (SAMPLE_BITS + 1);
	localparam int LIM  = (1 << (SAMPLE_BITS + 1)) - 1;

	logic [SAMPLE_W+SAMPLE_BITS-1:0] sample_ext;
	logic signed [SAMPLE_BITS-1:0]   x_s1;
	logic signed [SAMPLE_BITS-1:0]   prior_x_q;
	logic signed [F_W-1:0]           prior_f_q;
	logic signed [F_W-1:0]           f_s2;
	logic signed [D_W-1:0]           d;
	logic signed [P_W-1:0]           prod;
	logic signed [P_W-1:0]           prod_rnd;
	logic signed [R_W-1:0]           f_rnd;
	logic signed [F_W-1:0]           f;
	logic signed [2*F_W-1:0]         sq_full;

	// only the low SAMPLE_BITS bits of the field carry the sample
	assign sample_ext = {{SAMPLE_BITS{1'b0}}, sample};

	assign d        = D_W'(prior_f_q) + D_W'(x_s1) - D_W'(prior_x_q);
	assign prod     = P_W'($signed({1'b0, hp_alpha})) * P_W'(d);
	assign prod_rnd = prod + P_W'(32768);
	assign f_rnd    = $signed(prod_rnd[P_W-1:16]);

	always_comb begin
		if (st_s1.idx == '0) begin
			f = '0;
		end else if (f_rnd > LIM) begin
			f = F_W'(LIM);
		end else if (f_rnd < -LIM) begin
			f = F_W'(-LIM);
		end else begin
			f = F_W'(f_rnd);
		end
	end

	assign sq_full = (2*F_W)'(f_s2) * (2*F_W)'(f_s2);

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1 <= $signed(sample_ext[SAMPLE_BITS-1:0]);
		end
		if (st_s1.vld) begin
			f_s2 <= f;
		end
		if (st_s2.vld) begin
			sq_s3 <= sq_full[SQ_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prior_x_q <= '0;
			prior_f_q <= '0;
		end else if (st_s1.vld) begin
			// a new recording starts from a clean filter
			if (st_s1.last) begin
				prior_x_q <= '0;
				prior_f_q <= '0;
			end else begin
				prior_x_q <= x_s1;
				prior_f_q <= f;
			end
		end
	end

endmodule

// ===== hdl/tpd_energy.sv =====
// square memory with running window sum and re-summation sweep
module tpd_energy import tpd_pkg::*; #(
	parameter int MAX_WINDOW  = 64,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  stage_t                       st_s1,
	input  stage_t                       st_s3,
	input  logic [WIN_W-1:0]             window_len,
	input  logic                         sweep_start,
	input  logic [WIN_W-1:0]             sweep_len,
	input  logic [2*(SAMPLE_BITS+1)-1:0] sq_s3,
	output logic [ENERGY_W-1:0]          e_s4,
	output logic                         busy
);

	localparam int SQ_W  = 2 * (SAMPLE_BITS + 1);
	localparam int SUM_W = SQ_W + $clog2(MAX_WINDOW + 1);
	localparam int PTR_W = $clog2(MAX_WINDOW);
	localparam int W_W   = $clog2(MAX_WINDOW + 1);
	localparam int CMP_W = (SUM_W > ENERGY_W) ? SUM_W : ENERGY_W;

	function automatic logic [W_W-1:0] clamp_win(input logic [WIN_W-1:0] v);
		logic [W_W-1:0] r;
		if (32'(v) < MIN_WINDOW) begin
			r = W_W'(MIN_WINDOW);
		end else if (32'(v) > MAX_WINDOW) begin
			r = W_W'(MAX_WINDOW);
		end else begin
			r = W_W'(v);
		end
		return r;
	endfunction

	logic [SQ_W-1:0]       line_mem [MAX_WINDOW];
	logic [MAX_WINDOW-1:0] line_vld_q;
	logic [SQ_W-1:0]       rd_q;
	logic                  rd_vld_q;
	logic [PTR_W-1:0]      ptr_q;
	logic [PTR_W-1:0]      wa_s1, wa_s2, wa_s3;
	logic [SQ_W-1:0]       old_s2, old_s3;
	logic [SUM_W-1:0]      sum_q;
	logic [SUM_W-1:0]      sum_next;
	logic [CMP_W-1:0]      sum_ext;
	logic [W_W-1:0]        w_cur;
	logic [PTR_W+1:0]      ra_sum;
	logic [PTR_W-1:0]      ra_item;
	logic [PTR_W-1:0]      ra;
	logic                  re;
	logic                  we;
	logic [W_W-1:0]        sweep_left_q;
	logic [PTR_W-1:0]      sweep_addr_q;
	logic                  sweep_pend_q;
	logic [PTR_W-1:0]      ptr_prev;

	assign w_cur = clamp_win(window_len);

	// entry that drops out of the window: ptr - w, wrapped
	always_comb begin
		ra_sum = (PTR_W+2)'(ptr_q) + (PTR_W+2)'(MAX_WINDOW) - (PTR_W+2)'(w_cur);
		if (ra_sum >= (PTR_W+2)'(MAX_WINDOW)) begin
			ra_sum = ra_sum - (PTR_W+2)'(MAX_WINDOW);
		end
		ra_item = ra_sum[PTR_W-1:0];
	end

	assign ptr_prev = (ptr_q == '0) ? PTR_W'(MAX_WINDOW - 1) : ptr_q - 1'b1;

	assign re   = accept || (sweep_left_q != '0);
	assign ra   = accept ? ra_item : sweep_addr_q;
	assign we   = st_s3.vld && !st_s3.last;
	assign busy = (sweep_left_q != '0) || sweep_pend_q;

	assign sum_next = sum_q + SUM_W'(sq_s3) - SUM_W'(old_s3);
	assign sum_ext  = CMP_W'(sum_next);

	always_ff @(posedge clk) begin
		if (we) begin
			line_mem[wa_s3] <= sq_s3;
		end
		if (re) begin
			rd_q     <= line_mem[ra];
			rd_vld_q <= line_vld_q[ra];
		end
		if (accept) begin
			wa_s1 <= ptr_q;
		end
		if (st_s1.vld) begin
			wa_s2  <= wa_s1;
			old_s2 <= rd_vld_q ? rd_q : '0;
		end
		wa_s3  <= wa_s2;
		old_s3 <= old_s2;
		if (st_s3.vld) begin
			e_s4 <= (sum_ext > CMP_W'(ENERGY_MAX)) ? ENERGY_MAX : sum_ext[ENERGY_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_vld_q   <= '0;
			ptr_q        <= '0;
			sum_q        <= '0;
			sweep_left_q <= '0;
			sweep_addr_q <= '0;
			sweep_pend_q <= 1'b0;
		end else begin
			// end of recording empties the whole line at once
			if (st_s1.vld && st_s1.last) begin
				line_vld_q <= '0;
			end else if (we) begin
				line_vld_q[wa_s3] <= 1'b1;
			end

			if (accept) begin
				ptr_q <= (ptr_q == PTR_W'(MAX_WINDOW - 1)) ? '0 : ptr_q + 1'b1;
			end else if (st_s1.vld && st_s1.last) begin
				ptr_q <= '0;
			end

			if (sweep_start) begin
				sum_q        <= '0;
				sweep_left_q <= clamp_win(sweep_len);
				sweep_addr_q <= ptr_prev;
				sweep_pend_q <= 1'b0;
			end else begin
				if (sweep_left_q != '0) begin
					sweep_left_q <= sweep_left_q - 1'b1;
					sweep_addr_q <= (sweep_addr_q == '0) ? PTR_W'(MAX_WINDOW - 1)
						: sweep_addr_q - 1'b1;
					sweep_pend_q <= 1'b1;
				end else begin
					sweep_pend_q <= 1'b0;
				end
				if (sweep_pend_q) begin
					sum_q <= sum_q + (rd_vld_q ? SUM_W'(rd_q) : '0);
				end else if (st_s3.vld) begin
					sum_q <= st_s3.last ? '0 : sum_next;
				end
			end
		end
	end

`ifndef SYNTH
	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !busy)
		else $error("sample taken during window re-summation");
`endif

endmodule

// ===== hdl/tpd_region.sv =====
// detection region tracking and result queue
module tpd_region import tpd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  stage_t              st_s4,
	input  logic [ENERGY_W-1:0] e_s4,
	input  logic [ENERGY_W-1:0] energy_threshold,
	input  logic [REFR_W-1:0]   refractory_len,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [71:0]         m_tdata,
	output logic [OQ_CNT_W-1:0] oq_count
);

	logic                region_open_q, region_open_n;
	logic [REFR_W-1:0]   region_left_q, region_left_n;
	logic [ENERGY_W-1:0] best_energy_q, best_energy_n;
	logic [IDX_W-1:0]    best_index_q, best_index_n;
	logic                emit;
	logic                push;
	logic                pop;

	out_item_t           oq_mem [OQ_DEPTH];
	logic [OQ_PTR_W-1:0] oq_wr_q, oq_rd_q;
	logic [OQ_CNT_W-1:0] oq_count_q;

	always_comb begin
		region_open_n = region_open_q;
		region_left_n = region_left_q;
		best_energy_n = best_energy_q;
		best_index_n  = best_index_q;
		emit          = 1'b0;
		if (st_s4.vld) begin
			if (region_open_q) begin
				// strict compare keeps the earliest maximum
				if (e_s4 > best_energy_q) begin
					best_energy_n = e_s4;
					best_index_n  = st_s4.idx;
				end
				if (region_left_q != '0) begin
					region_left_n = region_left_q - 1'b1;
				end
				if (region_left_n == '0 || st_s4.last) begin
					emit          = 1'b1;
					region_open_n = 1'b0;
				end
			end else if (st_s4.idx != '0 && !st_s4.last && e_s4 >= energy_threshold) begin
				region_open_n = 1'b1;
				region_left_n = (refractory_len == '0) ? REFR_W'(1) : refractory_len;
				best_energy_n = e_s4;
				best_index_n  = st_s4.idx;
			end
			if (st_s4.last) begin
				region_open_n = 1'b0;
			end
		end
	end

	assign push     = emit;
	assign pop      = m_tvalid && m_tready;
	assign m_tvalid = (oq_count_q != '0);
	assign m_tdata  = oq_mem[oq_rd_q];
	assign oq_count = oq_count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			oq_mem[oq_wr_q] <= '{energy: best_energy_n, idx: best_index_n};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_open_q <= 1'b0;
			region_left_q <= '0;
			best_energy_q <= '0;
			best_index_q  <= '0;
			oq_wr_q       <= '0;
			oq_rd_q       <= '0;
			oq_count_q    <= '0;
		end else begin
			region_open_q <= region_open_n;
			region_left_q <= region_left_n;
			best_energy_q <= best_energy_n;
			best_index_q  <= best_index_n;
			if (push) begin
				oq_wr_q <= oq_wr_q + 1'b1;
			end
			if (pop) begin
				oq_rd_q <= oq_rd_q + 1'b1;
			end
			if (push && !pop) begin
				oq_count_q <= oq_count_q + 1'b1;
			end else if (pop && !push) begin
				oq_count_q <= oq_count_q - 1'b1;
			end
		end
	end

`ifndef SYNTH
	a_oq_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (oq_count_q < OQ_CNT_W'(OQ_DEPTH)) || pop)
		else $error("result queue overflow");
`endif

endmodule

// ===== hdl/transient_peak_detector.sv =====
// top level: configuration registers, sample handshake and stage control
// a result is queued as its closing sample reaches s4, then offered on m_tvalid from the queue
// a sample waits while the previous one holds the single-entry input stage feeding the filter
//   feedback register; s_tready also drops while the 4-entry result queue is committed and
//   during a window_len write's re-summation sweep of w entries (w the clamped window)
// reset: arst_n clears all stream state at once; square memory entries are marked empty
module transient_peak_detector import tpd_pkg::*; #(
	parameter int MAX_WINDOW  = 64,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [15:0]           s_tdata,   // sample
	input  logic                  s_tlast,   // last_sample
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [71:0]           m_tdata,   // event_sample, peak_energy
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int SQ_W = 2 * (SAMPLE_BITS + 1);

	logic [ALPHA_W-1:0]  hp_alpha_q;
	logic [WIN_W-1:0]    window_len_q;
	logic [ENERGY_W-1:0] energy_threshold_q;
	logic [REFR_W-1:0]   refractory_len_q;

	logic                s_accept;
	logic [IDX_W-1:0]    sample_index_q;
	stage_t              st_s1, st_s2, st_s3, st_s4;
	logic [SQ_W-1:0]     sq_s3;
	logic [ENERGY_W-1:0] e_s4;
	logic                sweep_busy;
	logic                sweep_start;
	logic [OQ_CNT_W-1:0] oq_count;
	logic [OQ_CNT_W:0]   committed;

	// every sample in flight may still need a queue slot
	assign committed = (OQ_CNT_W+1)'(st_s1.vld) + (OQ_CNT_W+1)'(st_s2.vld)
		+ (OQ_CNT_W+1)'(st_s3.vld) + (OQ_CNT_W+1)'(st_s4.vld) + (OQ_CNT_W+1)'(oq_count);

	assign s_tready    = !st_s1.vld && !sweep_busy && (committed < (OQ_CNT_W+1)'(OQ_DEPTH));
	assign s_accept    = s_tvalid && s_tready;
	assign sweep_start = cfg_we && (cfg_reg_t'(cfg_idx) == REG_WINDOW_LEN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hp_alpha_q         <= HP_ALPHA_RST;
			window_len_q       <= WINDOW_RST;
			energy_threshold_q <= THRESHOLD_RST;
			refractory_len_q   <= REFR_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_HP_ALPHA:   hp_alpha_q         <= cfg_data[ALPHA_W-1:0];
				REG_WINDOW_LEN: window_len_q       <= cfg_data[WIN_W-1:0];
				REG_THRESHOLD:  energy_threshold_q <= cfg_data[ENERGY_W-1:0];
				REG_REFRACTORY: refractory_len_q   <= cfg_data[REFR_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_index_q <= '0;
			st_s1          <= '0;
			st_s2          <= '0;
			st_s3          <= '0;
			st_s4          <= '0;
		end else begin
			if (s_accept) begin
				if (s_tlast) begin
					sample_index_q <= '0;
				end else if (sample_index_q != '1) begin
					sample_index_q <= sample_index_q + 1'b1;
				end
			end
			st_s1 <= '{vld: s_accept, last: s_tlast, idx: sample_index_q};
			st_s2 <= st_s1;
			st_s3 <= st_s2;
			st_s4 <= st_s3;
		end
	end

	tpd_filter #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_filter (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (s_accept),
		.sample  (s_tdata),
		.hp_alpha(hp_alpha_q),
		.st_s1   (st_s1),
		.st_s2   (st_s2),
		.sq_s3   (sq_s3)
	);

	tpd_energy #(
		.MAX_WINDOW (MAX_WINDOW),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_energy (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (s_accept),
		.st_s1      (st_s1),
		.st_s3      (st_s3),
		.window_len (window_len_q),
		.sweep_start(sweep_start),
		.sweep_len  (cfg_data[WIN_W-1:0]),
		.sq_s3      (sq_s3),
		.e_s4       (e_s4),
		.busy       (sweep_busy)
	);

	tpd_region u_region (
		.clk             (clk),
		.arst_n          (arst_n),
		.st_s4           (st_s4),
		.e_s4            (e_s4),
		.energy_threshold(energy_threshold_q),
		.refractory_len  (refractory_len_q),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.oq_count        (oq_count)
	);

`ifndef SYNTH
	a_accept_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> !s_accept)
		else $error("samples accepted in adjacent cycles");
`endif

endmodule
